FILE: design/blpt_pkg.sv
// Shared types, byte constants and character classing for the byte-level pretokenizer.
package blpt_pkg;

    // Input word: one text byte and the end-of-text mark.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } text_t;

    // Output word: one released byte with its chunk and step marks.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       chunk_end;
        logic       run_last;
    } token_t;

    // Upper bound on the words that one input byte can release.
    localparam int MAX_RESULTS = 4;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Words released by one step, in order, with their count.
    typedef struct packed {
        logic [RES_CNT_W-1:0]         count;
        token_t [MAX_RESULTS-1:0]     item;
    } step_res_t;

    // Default address width of the output queue.
    localparam int FIFO_AW = 3;

    // Open run classes.
    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_LETTER = 3'd1;
    localparam logic [2:0] CLS_DIGIT  = 3'd2;
    localparam logic [2:0] CLS_SYMBOL = 3'd3;
    localparam logic [2:0] CLS_SPACE  = 3'd4;
    localparam logic [2:0] CLS_QUOTE  = 3'd5;

    // Byte values that the rules look for.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_HIGH  = 8'h80;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_V     = 8'h76;

    // True for space, tab, LF, CR, FF and VT.
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
    endfunction

    // Class of one byte; bytes from 0x80 up count as letters.
    function automatic logic [2:0] class_of(input logic [7:0] c);
        logic [2:0] k;
        if (((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
            (c >= CH_HIGH))
        begin
            k = CLS_LETTER;
        end
        else if ((c >= 8'h30) && (c <= 8'h39))
        begin
            k = CLS_DIGIT;
        end
        else if (is_ws(c))
        begin
            k = CLS_SPACE;
        end
        else
        begin
            k = CLS_SYMBOL;
        end
        return k;
    endfunction

endpackage

FILE: design/blpt_step.sv
// Chunk-boundary logic: run state, held bytes and the words released per input byte.
module blpt_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  blpt_pkg::text_t     text,
    output blpt_pkg::step_res_t res
);

    // Run state. Only two of the held-byte slots are ever needed.
    logic [7:0] h0_reg, h1_reg;
    logic [7:0] h0_next, h1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] cls_reg, cls_next;
    logic [1:0] wsl_reg, wsl_next;

    logic [blpt_pkg::RES_CNT_W-1:0] n;
    logic [7:0] c;
    logic [7:0] want;
    logic [2:0] k;
    logic       do_run;
    logic       do_start;
    logic       start_lead;

    // One pass over the byte: feed the open run, start a new one, then flush on last.
    always_comb
    begin
        res      = '0;
        n        = '0;
        h0_next  = h0_reg;
        h1_next  = h1_reg;
        cnt_next = cnt_reg;
        cls_next = cls_reg;
        wsl_next = wsl_reg;
        c        = text.text_byte;
        k        = blpt_pkg::class_of(c);
        want     = (h1_reg == blpt_pkg::CH_L) ? blpt_pkg::CH_L : blpt_pkg::CH_E;
        do_run     = 1'b0;
        do_start   = 1'b0;
        start_lead = 1'b0;

        case (cls_reg) inside
            blpt_pkg::CLS_LETTER, blpt_pkg::CLS_DIGIT, blpt_pkg::CLS_SYMBOL:
            begin
                do_run = 1'b1;
            end
            blpt_pkg::CLS_SPACE:
            begin
                if (blpt_pkg::is_ws(c))
                begin
                    if (wsl_reg < 2'd2)
                    begin
                        h1_next  = c;
                        cnt_next = 2'd2;
                        wsl_next = 2'd2;
                    end
                    else
                    begin
                        res.item[n[1:0]] = '{out_byte: h0_next, chunk_end: 1'b0,
                                             run_last: 1'b0};
                        n       = n + 1'b1;
                        h0_next = h1_next;
                        h1_next = c;
                    end
                end
                else
                begin
                    // All but the last whitespace byte close as their own chunk.
                    if (wsl_reg == 2'd2)
                    begin
                        res.item[n[1:0]] = '{out_byte: h0_next, chunk_end: 1'b1,
                                             run_last: 1'b0};
                        n        = n + 1'b1;
                        h0_next  = h1_next;
                        cnt_next = 2'd1;
                        wsl_next = 2'd1;
                    end
                    // A final plain space leads the next run; other whitespace stands alone.
                    start_lead = (h0_next == blpt_pkg::CH_SPACE);
                    res.item[n[1:0]] = '{out_byte: h0_next, chunk_end: !start_lead,
                                         run_last: 1'b0};
                    n        = n + 1'b1;
                    do_start = 1'b1;
                end
            end
            blpt_pkg::CLS_QUOTE:
            begin
                if (cnt_reg < 2'd2)
                begin
                    if ((c == blpt_pkg::CH_S) || (c == blpt_pkg::CH_T) ||
                        (c == blpt_pkg::CH_M) || (c == blpt_pkg::CH_D))
                    begin
                        res.item[n[1:0]] = '{out_byte: h0_next, chunk_end: 1'b0,
                                             run_last: 1'b0};
                        n = n + 1'b1;
                        res.item[n[1:0]] = '{out_byte: c, chunk_end: 1'b1, run_last: 1'b0};
                        n = n + 1'b1;
                        cls_next = blpt_pkg::CLS_NONE;
                        cnt_next = 2'd0;
                        wsl_next = 2'd0;
                    end
                    else if ((c == blpt_pkg::CH_R) || (c == blpt_pkg::CH_V) ||
                             (c == blpt_pkg::CH_L))
                    begin
                        h1_next  = c;
                        cnt_next = 2'd2;
                    end
                    else
                    begin
                        cls_next = blpt_pkg::CLS_SYMBOL;
                        do_run   = 1'b1;
                    end
                end
                else if (c == want)
                begin
                    res.item[n[1:0]] = '{out_byte: h0_next, chunk_end: 1'b0, run_last: 1'b0};
                    n = n + 1'b1;
                    res.item[n[1:0]] = '{out_byte: h1_next, chunk_end: 1'b0, run_last: 1'b0};
                    n = n + 1'b1;
                    res.item[n[1:0]] = '{out_byte: c, chunk_end: 1'b1, run_last: 1'b0};
                    n = n + 1'b1;
                    cls_next = blpt_pkg::CLS_NONE;
                    cnt_next = 2'd0;
                    wsl_next = 2'd0;
                end
                else
                begin
                    // Failed two-letter contraction: the quote closes, the letter goes on.
                    res.item[n[1:0]] = '{out_byte: h0_next, chunk_end: 1'b1, run_last: 1'b0};
                    n        = n + 1'b1;
                    h0_next  = h1_next;
                    cnt_next = 2'd1;
                    cls_next = blpt_pkg::CLS_LETTER;
                    do_run   = 1'b1;
                end
            end
            default:
            begin
                do_start = 1'b1;
            end
        endcase

        // Continue or close a letter, digit or symbol run.
        if (do_run)
        begin
            if (k == cls_next)
            begin
                res.item[n[1:0]] = '{out_byte: h0_next, chunk_end: 1'b0, run_last: 1'b0};
                n       = n + 1'b1;
                h0_next = c;
            end
            else
            begin
                res.item[n[1:0]] = '{out_byte: h0_next, chunk_end: 1'b1, run_last: 1'b0};
                n        = n + 1'b1;
                do_start = 1'b1;
            end
        end

        // Open a new chunk with this byte.
        if (do_start)
        begin
            h0_next  = c;
            cnt_next = 2'd1;
            wsl_next = 2'd0;
            if (k == blpt_pkg::CLS_SPACE)
            begin
                cls_next = blpt_pkg::CLS_SPACE;
                wsl_next = 2'd1;
            end
            else if ((c == blpt_pkg::CH_QUOTE) && !start_lead)
            begin
                cls_next = blpt_pkg::CLS_QUOTE;
            end
            else
            begin
                cls_next = k;
            end
        end

        // End of text: release everything still held.
        if (text.text_last)
        begin
            case (cls_next) inside
                blpt_pkg::CLS_LETTER, blpt_pkg::CLS_DIGIT, blpt_pkg::CLS_SYMBOL:
                begin
                    res.item[n[1:0]] = '{out_byte: h0_next, chunk_end: 1'b1, run_last: 1'b0};
                    n = n + 1'b1;
                end
                blpt_pkg::CLS_SPACE:
                begin
                    res.item[n[1:0]] = '{out_byte: h0_next, chunk_end: (cnt_next < 2'd2),
                                         run_last: 1'b0};
                    n = n + 1'b1;
                    if (cnt_next >= 2'd2)
                    begin
                        res.item[n[1:0]] = '{out_byte: h1_next, chunk_end: 1'b1,
                                             run_last: 1'b0};
                        n = n + 1'b1;
                    end
                end
                blpt_pkg::CLS_QUOTE:
                begin
                    res.item[n[1:0]] = '{out_byte: h0_next, chunk_end: 1'b1, run_last: 1'b0};
                    n = n + 1'b1;
                    if (cnt_next >= 2'd2)
                    begin
                        res.item[n[1:0]] = '{out_byte: h1_next, chunk_end: 1'b1,
                                             run_last: 1'b0};
                        n = n + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            cls_next = blpt_pkg::CLS_NONE;
            cnt_next = 2'd0;
            wsl_next = 2'd0;
        end

        // Mark the final word of the step.
        if (n != '0)
        begin
            res.item[2'(n - 1'b1)].run_last = 1'b1;
        end
        res.count = fire ? n : '0;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_reg <= blpt_pkg::CLS_NONE;
            cnt_reg <= 2'd0;
            wsl_reg <= 2'd0;
        end
        else if (fire)
        begin
            cls_reg <= cls_next;
            cnt_reg <= cnt_next;
            wsl_reg <= wsl_next;
        end
    end

    // Held bytes carry no reset.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            h0_reg <= h0_next;
            h1_reg <= h1_next;
        end
    end

`ifndef SYNTHESIS
    a_none_iff_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cls_reg == blpt_pkg::CLS_NONE) == (cnt_reg == 2'd0))
        else $error("run class and held count disagree");
    a_space_len: assert property (@(posedge clk) disable iff (!rst_n)
        (cls_reg == blpt_pkg::CLS_SPACE) |-> (wsl_reg == cnt_reg))
        else $error("whitespace length differs from held count");
    a_two_held: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |->
        ((cls_reg == blpt_pkg::CLS_SPACE) || (cls_reg == blpt_pkg::CLS_QUOTE)))
        else $error("two bytes held outside whitespace or contraction");
`endif

endmodule

FILE: design/blpt_fifo.sv
// Output queue: takes up to four words per cycle, gives one word per cycle while token_stall is low.
module blpt_fifo #(
    parameter int AW = blpt_pkg::FIFO_AW
) (
    input  logic                clk,
    input  logic                rst_n,
    input  blpt_pkg::step_res_t push,
    output logic                room,
    output logic                token_valid,
    input  logic                token_stall,
    output blpt_pkg::token_t    token
);

    localparam int DEPTH = 1 << AW;

    blpt_pkg::token_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg, count_next;
    logic          pop;

    assign token_valid = (count_reg != '0);
    assign token       = mem[rd_ptr_reg];
    assign pop         = token_valid && !token_stall;
    // Room for the largest burst one step can push.
    assign room        = (count_reg <= (AW + 1)'(DEPTH - blpt_pkg::MAX_RESULTS));
    assign count_next  = count_reg + (AW + 1)'(push.count) - (AW + 1)'(pop);

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + AW'(push.count);
            rd_ptr_reg <= rd_ptr_reg + AW'(pop);
            count_reg  <= count_next;
        end
    end

    // Storage: the step's words land at consecutive slots.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < blpt_pkg::MAX_RESULTS; i++)
        begin
            if (i < int'(push.count))
            begin
                mem[wr_ptr_reg + AW'(i)] <= push.item[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != '0) |-> room)
        else $error("queue pushed without room for a full burst");
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW + 1)'(DEPTH))
        else $error("queue count beyond depth");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (pop || (push.count != '0)) |=> (count_reg == $past(count_next)))
        else $error("queue count lost a push or pop");
    a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!token_valid && (push.count == '0)) |=> !token_valid)
        else $error("queue became valid without a push");
`endif

endmodule

FILE: design/byte_level_pretokenizer_top.sv
// Byte-level pretokenizer top: input register, boundary logic and output queue.
// A byte is captured in the input register and classed by the boundary logic, which
// writes its words into the output queue once the byte's chunk boundary is known.
// Throughput: one byte per cycle; every byte leaves as exactly one word. Input stalls
// only while the output queue has fewer than four free slots (depth set by FIFO_AW).
// Reset clears the run state and the queue; held bytes and queue slots are not cleared.
module byte_level_pretokenizer_top #(
    parameter int FIFO_AW = blpt_pkg::FIFO_AW
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             text_valid,
    output logic             text_stall,
    input  blpt_pkg::text_t  text,
    output logic             token_valid,
    input  logic             token_stall,
    output blpt_pkg::token_t token
);

    logic                text_valid_reg;
    blpt_pkg::text_t     text_reg;
    logic                room;
    logic                fire;
    logic                accept;
    blpt_pkg::step_res_t res;

    // The held word moves on when the queue can take a full burst.
    assign fire       = text_valid_reg && room;
    assign text_stall = text_valid_reg && !room;
    assign accept     = text_valid && !text_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            text_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            text_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            text_reg <= text;
        end
    end

    blpt_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .text  (text_reg),
        .res   (res)
    );

    blpt_fifo #(
        .AW (FIFO_AW)
    ) u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (res),
        .room        (room),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token       (token)
    );

endmodule

FILE: tb/byte_level_pretokenizer_top_tb.sv
// Self-checking testbench for the byte-level pretokenizer: directed texts, then random texts.
module byte_level_pretokenizer_top_tb;

    typedef logic [7:0] byte_q_t[$];

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_BYTES = 150;
    localparam int DRAIN_CYCLES = 20;

    logic              clk;
    logic              rst_n;
    logic              text_valid;
    logic              text_stall;
    blpt_pkg::text_t   text;
    logic              token_valid;
    logic              token_stall = 1'b0;
    blpt_pkg::token_t  token;

    // Predicted pretokenizer state.
    logic [7:0] pend_bytes [3];
    logic [1:0] pend_count;
    logic [2:0] run_class;
    logic       run_lead;
    logic [1:0] ws_len;

    // Words released by the byte being predicted, and all words still to arrive.
    blpt_pkg::token_t step_words[$];
    blpt_pkg::token_t expected_tokens[$];

    byte_q_t draft;
    int      mismatches;
    int      cycle_count = 0;
    int      random_sent;
    logic    calm;

    byte_level_pretokenizer_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text        (text),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token       (token)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter for the run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Stop a run that hangs.
    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("tb: failure");
        $finish;
    end

    // Character class, with case folding for the ASCII letters.
    function automatic logic [2:0] byte_kind(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c[7])
            return blpt_pkg::CLS_LETTER;
        if ((folded >= 8'h61) && (folded <= 8'h7A))
            return blpt_pkg::CLS_LETTER;
        if ((c >= 8'h30) && (c <= 8'h39))
            return blpt_pkg::CLS_DIGIT;
        case (c)
            blpt_pkg::CH_SPACE, blpt_pkg::CH_TAB, blpt_pkg::CH_LF, blpt_pkg::CH_VT,
            blpt_pkg::CH_FF, blpt_pkg::CH_CR: return blpt_pkg::CLS_SPACE;
            default: return blpt_pkg::CLS_SYMBOL;
        endcase
    endfunction

    function automatic void release_word(input logic [7:0] b, input logic ends);
        blpt_pkg::token_t w;
        w.out_byte  = b;
        w.chunk_end = ends;
        w.run_last  = 1'b0;
        if (step_words.size() < blpt_pkg::MAX_RESULTS)
            step_words = {step_words, w};
    endfunction

    function automatic void end_all_chunks();
        run_class  = blpt_pkg::CLS_NONE;
        pend_count = 2'd0;
        run_lead   = 1'b0;
        ws_len     = 2'd0;
    endfunction

    function automatic void open_chunk(input logic [7:0] c, input logic lead);
        logic [2:0] k;
        k = byte_kind(c);
        pend_bytes[0] = c;
        pend_count    = 2'd1;
        run_lead      = lead;
        ws_len        = 2'd0;
        if (k == blpt_pkg::CLS_SPACE)
        begin
            run_class = blpt_pkg::CLS_SPACE;
            ws_len    = 2'd1;
        end
        else if ((c == blpt_pkg::CH_QUOTE) && !lead)
        begin
            run_class = blpt_pkg::CLS_QUOTE;
        end
        else
        begin
            run_class = k;
        end
    endfunction

    // A letter, digit or symbol run either grows or closes.
    function automatic void extend_run(input logic [7:0] c);
        if (byte_kind(c) == run_class)
        begin
            release_word(pend_bytes[0], 1'b0);
            pend_bytes[0] = c;
        end
        else
        begin
            release_word(pend_bytes[0], 1'b1);
            open_chunk(c, 1'b0);
        end
    endfunction

    // Predict the words released by one accepted byte and queue them.
    function automatic void predict_byte(input logic [7:0] c, input logic last);
        logic [7:0] second;
        logic [7:0] closer;
        step_words.delete();
        case (run_class)
            blpt_pkg::CLS_LETTER, blpt_pkg::CLS_DIGIT, blpt_pkg::CLS_SYMBOL:
            begin
                extend_run(c);
            end
            blpt_pkg::CLS_SPACE:
            begin
                if (byte_kind(c) == blpt_pkg::CLS_SPACE)
                begin
                    if (ws_len < 2)
                    begin
                        pend_bytes[1] = c;
                        pend_count    = 2'd2;
                        ws_len        = 2'd2;
                    end
                    else
                    begin
                        release_word(pend_bytes[0], 1'b0);
                        pend_bytes[0] = pend_bytes[1];
                        pend_bytes[1] = c;
                    end
                end
                else
                begin
                    // All but the last whitespace byte close as one chunk.
                    if (ws_len >= 2)
                    begin
                        release_word(pend_bytes[0], 1'b1);
                        pend_bytes[0] = pend_bytes[1];
                        pend_count    = 2'd1;
                        ws_len        = 2'd1;
                    end
                    if (pend_bytes[0] == blpt_pkg::CH_SPACE)
                    begin
                        release_word(pend_bytes[0], 1'b0);
                        open_chunk(c, 1'b1);
                    end
                    else
                    begin
                        release_word(pend_bytes[0], 1'b1);
                        open_chunk(c, 1'b0);
                    end
                end
            end
            blpt_pkg::CLS_QUOTE:
            begin
                if (pend_count < 2)
                begin
                    if ((c == blpt_pkg::CH_S) || (c == blpt_pkg::CH_T) ||
                        (c == blpt_pkg::CH_M) || (c == blpt_pkg::CH_D))
                    begin
                        release_word(pend_bytes[0], 1'b0);
                        release_word(c, 1'b1);
                        end_all_chunks();
                    end
                    else if ((c == blpt_pkg::CH_R) || (c == blpt_pkg::CH_V) ||
                             (c == blpt_pkg::CH_L))
                    begin
                        pend_bytes[1] = c;
                        pend_count    = 2'd2;
                    end
                    else
                    begin
                        run_class = blpt_pkg::CLS_SYMBOL;
                        extend_run(c);
                    end
                end
                else
                begin
                    second = pend_bytes[1];
                    closer = (second == blpt_pkg::CH_L) ? blpt_pkg::CH_L : blpt_pkg::CH_E;
                    if (c == closer)
                    begin
                        release_word(pend_bytes[0], 1'b0);
                        release_word(second, 1'b0);
                        release_word(c, 1'b1);
                        end_all_chunks();
                    end
                    else
                    begin
                        // Failed two-letter contraction: the quote stands alone.
                        release_word(pend_bytes[0], 1'b1);
                        pend_bytes[0] = second;
                        pend_count    = 2'd1;
                        run_class     = blpt_pkg::CLS_LETTER;
                        run_lead      = 1'b0;
                        extend_run(c);
                    end
                end
            end
            default:
            begin
                open_chunk(c, 1'b0);
            end
        endcase

        // End of text flushes every held byte.
        if (last)
        begin
            case (run_class)
                blpt_pkg::CLS_LETTER, blpt_pkg::CLS_DIGIT, blpt_pkg::CLS_SYMBOL:
                begin
                    release_word(pend_bytes[0], 1'b1);
                end
                blpt_pkg::CLS_SPACE:
                begin
                    if (pend_count >= 2)
                    begin
                        release_word(pend_bytes[0], 1'b0);
                        release_word(pend_bytes[1], 1'b1);
                    end
                    else
                    begin
                        release_word(pend_bytes[0], 1'b1);
                    end
                end
                blpt_pkg::CLS_QUOTE:
                begin
                    release_word(pend_bytes[0], 1'b1);
                    if (pend_count >= 2)
                        release_word(pend_bytes[1], 1'b1);
                end
                default:
                begin
                end
            endcase
            end_all_chunks();
        end

        if (step_words.size() > 0)
            step_words[step_words.size() - 1].run_last = 1'b1;
        foreach (step_words[i])
            expected_tokens = {expected_tokens, step_words[i]};
    endfunction

    // Send one word, idling at random first, and predict it once accepted.
    task automatic send_word(input logic [7:0] b, input logic last);
        while (!calm && ($urandom_range(0, 99) < 37))
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid       <= 1'b1;
        text.text_byte   <= b;
        text.text_last   <= last;
        @(posedge clk);
        while (text_stall)
            @(posedge clk);
        predict_byte(b, last);
    endtask

    // Send a whole text; the final byte carries the end mark.
    task automatic send_text(input byte_q_t bytes);
        foreach (bytes[i])
            send_word(bytes[i], i == bytes.size() - 1);
    endtask

    function automatic byte_q_t str_bytes(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++)
            q = {q, s[i]};
        return q;
    endfunction

    // Check one field of a received word.
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Output side: random stall and comparison of each accepted word.
    always @(posedge clk)
    begin : check_words
        blpt_pkg::token_t want;
        if (rst_n && token_valid && !token_stall)
        begin
            if (expected_tokens.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, token);
                mismatches++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("out_byte", want.out_byte, token.out_byte);
                check_field("chunk_end", {7'd0, want.chunk_end}, {7'd0, token.chunk_end});
                check_field("run_last", {7'd0, want.run_last}, {7'd0, token.run_last});
            end
        end
        token_stall <= !calm && ($urandom_range(0, 99) < 37);
    end

    // Random byte makers.
    function automatic logic [7:0] rand_letter();
        case ($urandom_range(0, 2))
            0: return 8'h61 + 8'($urandom_range(0, 25));
            1: return 8'h41 + 8'($urandom_range(0, 25));
            default: return blpt_pkg::CH_HIGH + 8'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic logic [7:0] rand_ws();
        case ($urandom_range(0, 9))
            0: return blpt_pkg::CH_TAB;
            1: return blpt_pkg::CH_LF;
            2: return blpt_pkg::CH_CR;
            3: return blpt_pkg::CH_FF;
            4: return blpt_pkg::CH_VT;
            default: return blpt_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] rand_symbol();
        logic [7:0] c;
        if ($urandom_range(0, 3) == 0)
            return blpt_pkg::CH_QUOTE;
        c = 8'($urandom_range(8'h21, 8'h7E));
        while (byte_kind(c) != blpt_pkg::CLS_SYMBOL)
            c = 8'($urandom_range(8'h21, 8'h7E));
        return c;
    endfunction

    function automatic logic [7:0] rand_contraction_letter();
        case ($urandom_range(0, 6))
            0: return blpt_pkg::CH_S;
            1: return blpt_pkg::CH_T;
            2: return blpt_pkg::CH_M;
            3: return blpt_pkg::CH_D;
            4: return blpt_pkg::CH_R;
            5: return blpt_pkg::CH_V;
            default: return blpt_pkg::CH_L;
        endcase
    endfunction

    // Append one piece of text: mostly well-formed runs, some broken or raw bytes.
    function automatic void grow_draft();
        int pick;
        int len;
        logic [7:0] x;
        pick = $urandom_range(0, 99);
        len  = $urandom_range(1, 4);
        if ((pick < 44) && ($urandom_range(0, 1) == 1))
            draft = {draft, blpt_pkg::CH_SPACE};
        if (pick < 20)
        begin
            repeat (len) draft = {draft, rand_letter()};
        end
        else if (pick < 32)
        begin
            repeat (len) draft = {draft, 8'h30 + 8'($urandom_range(0, 9))};
        end
        else if (pick < 44)
        begin
            repeat (len) draft = {draft, rand_symbol()};
        end
        else if (pick < 62)
        begin
            // Well-formed contraction.
            x = rand_contraction_letter();
            draft = {draft, blpt_pkg::CH_QUOTE};
            draft = {draft, x};
            if (x == blpt_pkg::CH_L)
                draft = {draft, blpt_pkg::CH_L};
            else if ((x == blpt_pkg::CH_R) || (x == blpt_pkg::CH_V))
                draft = {draft, blpt_pkg::CH_E};
        end
        else if (pick < 76)
        begin
            repeat (len) draft = {draft, rand_ws()};
        end
        else if (pick < 88)
        begin
            // Broken contraction.
            draft = {draft, blpt_pkg::CH_QUOTE};
            if ($urandom_range(0, 1) == 1)
                draft = {draft,
                         (($urandom_range(0, 1) == 1) ? blpt_pkg::CH_R : blpt_pkg::CH_L)};
            draft = {draft, 8'($urandom_range(0, 255))};
        end
        else
        begin
            draft = {draft, 8'($urandom_range(0, 255))};
        end
    endfunction

    // Contractions after a letter, a two-letter one, and a failed two-letter one.
    task automatic test_contractions();
        send_text(str_bytes("x's"));
        send_text(str_bytes("'ve'r!"));
    endtask

    // Quote inside a symbol run, after a leading space, before a letter, and at the end.
    task automatic test_quote_cases();
        send_text(str_bytes("!' 'q'q"));
        send_text(str_bytes("'"));
    endtask

    // Byte extremes, every whitespace byte, and whitespace closing the text.
    task automatic test_byte_extremes();
        byte_q_t q;
        q = {blpt_pkg::CH_HIGH, 8'hFF, 8'h00, 8'h30, 8'h39, blpt_pkg::CH_TAB,
             blpt_pkg::CH_LF, blpt_pkg::CH_CR, blpt_pkg::CH_FF, blpt_pkg::CH_VT,
             blpt_pkg::CH_SPACE, 8'h7A, blpt_pkg::CH_SPACE, blpt_pkg::CH_SPACE};
        send_text(q);
    endtask

    // Random texts, with a stretch where neither side idles.
    task automatic test_random_text();
        int pieces;
        random_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            calm = (random_sent >= 50) && (random_sent < 110);
            draft.delete();
            pieces = $urandom_range(1, 6);
            repeat (pieces) grow_draft();
            send_text(draft);
            random_sent += draft.size();
        end
        calm = 1'b0;
    endtask

    // Main sequence.
    initial
    begin
        rst_n       = 1'b0;
        text_valid  = 1'b0;
        text        = '0;
        calm        = 1'b0;
        mismatches  = 0;
        foreach (pend_bytes[i])
            pend_bytes[i] = 8'h00;
        end_all_chunks();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_contractions();
        test_quote_cases();
        test_byte_extremes();
        test_random_text();

        text_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if ((mismatches == 0) && (expected_tokens.size() == 0))
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
design/blpt_pkg.sv
design/blpt_step.sv
design/blpt_fifo.sv
design/byte_level_pretokenizer_top.sv
tb/byte_level_pretokenizer_top_tb.sv
